FILE: hw/rtl/rts_pkg.sv
// shared types, codes and helpers for the record table sort/search block
`timescale 1ns / 1ps
package rts_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int STRING_CHARS_DEF = 15;
    localparam int STR_W            = 128;

    localparam logic [2:0] FN_LIST        = 3'd0;
    localparam logic [2:0] FN_INSERT      = 3'd1;
    localparam logic [2:0] FN_FIND_SUR    = 3'd2;
    localparam logic [2:0] FN_FIND_GIVEN  = 3'd3;
    localparam logic [2:0] FN_FIND_PHONE  = 3'd4;
    localparam logic [2:0] FN_SORT_PHONE  = 3'd5;
    localparam logic [2:0] FN_UPDATE      = 3'd6;
    localparam logic [2:0] FN_SORT_SUR    = 3'd7;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_MISS   = 2'd2;
    localparam logic [1:0] STAT_BADPOS = 2'd3;

    typedef struct packed {
        logic [STR_W-1:0] surname;
        logic [STR_W-1:0] given;
        logic [STR_W-1:0] phone;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [2:0] func;
        rec_t       rec;
        logic [4:0] pos;
    } op_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] id;
        rec_t       rec;
        logic [1:0] status;
        logic       last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_L_RD,
        ST_L_OUT,
        ST_S_RD,
        ST_S_CMP,
        ST_S_END,
        ST_SK_RD,
        ST_SK_LAT,
        ST_SX_CMP,
        ST_SK_WR,
        ST_U_WR
    } state_t;

    // keep the first chars bytes, clear everything from the first zero byte on
    function automatic logic [STR_W-1:0] canon_str(input logic [STR_W-1:0] s, input int chars);
        logic [STR_W-1:0] r;
        logic             ended;
        logic [7:0]       c;
        r     = '0;
        ended = 1'b0;
        for (int b = 0; b < 16; b++)
        begin
            c = s[STR_W-1-8*b -: 8];
            if (b >= chars || c == 8'd0)
            begin
                ended = 1'b1;
            end
            r[STR_W-1-8*b -: 8] = ended ? 8'd0 : c;
        end
        return r;
    endfunction

    function automatic logic [STR_W-1:0] find_field(input rec_t r, input logic [2:0] fn);
        logic [STR_W-1:0] f;
        case (fn)
            FN_FIND_SUR:   f = r.surname;
            FN_FIND_GIVEN: f = r.given;
            default:       f = r.phone;
        endcase
        return f;
    endfunction

    function automatic logic [STR_W-1:0] sort_key(input rec_t r, input logic [2:0] fn);
        return (fn == FN_SORT_PHONE) ? r.phone : r.surname;
    endfunction

endpackage

FILE: hw/rtl/rts_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/rts_ctrl.sv
// operation sequencer: list, insert, search, exchange sort and update over the record ram
`timescale 1ns / 1ps
module rts_ctrl import rts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  op_t           op,
    output logic          busy,
    output res_t          res,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output rec_t          ram_wdata,
    output logic [AW-1:0] ram_raddr,
    input  rec_t          ram_rdata
);

    localparam int IW = CW + 6;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   k_reg, k_next;
    rec_t            rec_reg, rec_next;
    logic            pend_reg, pend_next;
    logic [CW-1:0]   pidx_reg, pidx_next;
    res_t            res_reg, res_next;

    logic [CW-1:0]   i_inc, k_inc;
    logic [IW-1:0]   pos_w, count_w, posm1_w;

    assign i_inc   = CW'(i_reg + 1'b1);
    assign k_inc   = CW'(k_reg + 1'b1);
    assign pos_w   = IW'(op.pos);
    assign count_w = IW'(count_reg);
    assign posm1_w = IW'(pos_w - 1'b1);

    function automatic logic [4:0] id_of(input logic [CW-1:0] idx);
        logic [IW-1:0] w;
        w = IW'(IW'(idx) + 1'b1);
        return w[4:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        k_reg          <= k_next;
        rec_reg        <= rec_next;
        pidx_reg       <= pidx_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        rec_next   = rec_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        res_next       = res_reg;
        res_next.valid = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = i_reg[AW-1:0];
        ram_wdata  = rec_reg;
        ram_raddr  = i_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                i_next     = '0;
                k_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_IDLE;
                case (op.func)
                    FN_LIST:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next = '{1'b1, 5'd0, '0, STAT_MISS, 1'b1};
                        end
                        else
                        begin
                            state_next = ST_L_RD;
                        end
                    end
                    FN_INSERT:
                    begin
                        if (count_w >= IW'(DEPTH))
                        begin
                            res_next = '{1'b1, 5'd0, '0, STAT_FULL, 1'b1};
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = op.rec;
                            count_next = CW'(count_reg + 1'b1);
                            res_next   = '{1'b1, id_of(count_reg), op.rec, STAT_OK, 1'b1};
                        end
                    end
                    FN_FIND_SUR, FN_FIND_GIVEN, FN_FIND_PHONE:
                    begin
                        state_next = ST_S_RD;
                    end
                    FN_SORT_PHONE, FN_SORT_SUR:
                    begin
                        state_next = ST_SK_RD;
                    end
                    default:
                    begin
                        if (pos_w == '0 || pos_w > count_w)
                        begin
                            res_next = '{1'b1, 5'd0, '0, STAT_BADPOS, 1'b1};
                        end
                        else
                        begin
                            ram_raddr  = posm1_w[AW-1:0];
                            state_next = ST_U_WR;
                        end
                    end
                endcase
            end

            ST_L_RD:
            begin
                state_next = ST_L_OUT;
            end

            ST_L_OUT:
            begin
                res_next = '{1'b1, id_of(i_reg), ram_rdata, STAT_OK, (i_inc == count_reg)};
                i_next   = i_inc;
                if (i_inc == count_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = i_inc[AW-1:0];
                    state_next = ST_L_OUT;
                end
            end

            ST_S_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = ST_S_END;
                end
                else
                begin
                    state_next = ST_S_CMP;
                end
            end

            ST_S_CMP:
            begin
                if (find_field(ram_rdata, op.func) == find_field(op.rec, op.func))
                begin
                    if (pend_reg)
                    begin
                        res_next = '{1'b1, id_of(pidx_reg), rec_reg, STAT_OK, 1'b0};
                    end
                    rec_next  = ram_rdata;
                    pidx_next = i_reg;
                    pend_next = 1'b1;
                end
                i_next     = i_inc;
                ram_raddr  = i_inc[AW-1:0];
                state_next = ST_S_RD;
            end

            ST_S_END:
            begin
                if (pend_reg)
                begin
                    res_next = '{1'b1, id_of(pidx_reg), rec_reg, STAT_OK, 1'b1};
                end
                else
                begin
                    res_next = '{1'b1, 5'd0, '0, STAT_MISS, 1'b1};
                end
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end

            ST_SK_RD:
            begin
                if (k_reg >= count_reg)
                begin
                    res_next   = '{1'b1, 5'd0, '0, STAT_OK, 1'b1};
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = k_reg[AW-1:0];
                    state_next = ST_SK_LAT;
                end
            end

            ST_SK_LAT:
            begin
                rec_next = ram_rdata;
                if (k_inc < count_reg)
                begin
                    ram_raddr  = k_inc[AW-1:0];
                    i_next     = k_inc;
                    state_next = ST_SX_CMP;
                end
                else
                begin
                    state_next = ST_SK_WR;
                end
            end

            ST_SX_CMP:
            begin
                if (sort_key(rec_reg, op.func) > sort_key(ram_rdata, op.func))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = i_reg[AW-1:0];
                    ram_wdata = rec_reg;
                    rec_next  = ram_rdata;
                end
                if (i_inc < count_reg)
                begin
                    ram_raddr = i_inc[AW-1:0];
                    i_next    = i_inc;
                end
                else
                begin
                    state_next = ST_SK_WR;
                end
            end

            ST_SK_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[AW-1:0];
                ram_wdata  = rec_reg;
                k_next     = k_inc;
                state_next = ST_SK_RD;
            end

            ST_U_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = posm1_w[AW-1:0];
                ram_wdata  = '{ram_rdata.surname, op.rec.given, ram_rdata.phone};
                res_next   = '{1'b1, op.pos, ram_wdata, STAT_OK, 1'b1};
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = res_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.valid && res_reg.status != STAT_OK) |-> res_reg.last)
        else $error("error result not marked last");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && state_reg == ST_IDLE))
        else $error("ram write while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        IW'(count_reg) <= IW'(DEPTH))
        else $error("record count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (IW'(count_reg) == IW'($past(count_reg)) + 1'b1))
        else $error("record count jumped");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (IW'(ram_waddr) < IW'(DEPTH)))
        else $error("ram write out of range");

endmodule

FILE: hw/rtl/record_table_sort_search.sv
// top level of the record table: input capture, string canonicalization, sequencer and ram
`timescale 1ns / 1ps
// A table of up to DEPTH records (surname, given name, phone; 16-byte strings
// packed first character most significant). An item is taken when start is high
// and busy is low; results come out at most one per cycle marked by result_valid,
// and the receiver must take them as they come (no back-pressure). The final
// result of each item has last set. The sort runs as a compare-swap loop, which
// reads one record and may write one per cycle through the single record memory.
// Busy drops in the cycle that carries the last result, so the next item can be
// taken in that same cycle. Strings are cut to STRING_CHARS characters and cleared
// from their first zero byte when they are taken in. After reset the table is
// empty; no clearing pass is needed.
module record_table_sort_search import rts_pkg::*; #(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int STRING_CHARS = STRING_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [63:0] surname_hi,
    input  logic [63:0] surname_lo,
    input  logic [63:0] given_hi,
    input  logic [63:0] given_lo,
    input  logic [63:0] phone_hi,
    input  logic [63:0] phone_lo,
    input  logic [4:0]  position,
    output logic        result_valid,
    output logic [4:0]  record_id,
    output logic [63:0] out_surname_hi,
    output logic [63:0] out_surname_lo,
    output logic [63:0] out_given_hi,
    output logic [63:0] out_given_lo,
    output logic [63:0] out_phone_hi,
    output logic [63:0] out_phone_lo,
    output logic [1:0]  status,
    output logic        last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          accept;
    op_t           op_reg;
    op_t           op_next;
    res_t          res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    rec_t          ram_wdata;
    rec_t          ram_rdata;

    // item is taken when start meets an idle sequencer
    assign accept = start && !busy;

    // strings are put in canonical form on the way in
    always_comb
    begin
        op_next.func        = func;
        op_next.rec.surname = canon_str({surname_hi, surname_lo}, STRING_CHARS);
        op_next.rec.given   = canon_str({given_hi, given_lo}, STRING_CHARS);
        op_next.rec.phone   = canon_str({phone_hi, phone_lo}, STRING_CHARS);
        op_next.pos         = position;
    end

    // operand register, held for the whole operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    rts_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op_reg),
        .busy      (busy),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // one record per entry: surname, given name, phone
    rts_ram #(
        .WIDTH(REC_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result ports straight from the sequencer's output register
    assign result_valid   = res.valid;
    assign record_id      = res.id;
    assign out_surname_hi = res.rec.surname[127:64];
    assign out_surname_lo = res.rec.surname[63:0];
    assign out_given_hi   = res.rec.given[127:64];
    assign out_given_lo   = res.rec.given[63:0];
    assign out_phone_hi   = res.rec.phone[127:64];
    assign out_phone_lo   = res.rec.phone[63:0];
    assign status         = res.status;
    assign last           = res.last;

endmodule

FILE: bench/tb.sv
// self-checking testbench for the record table sort/search block
`timescale 1ns / 1ps
module tb;
    import rts_pkg::*;

    localparam int TBL_DEPTH = 16;
    localparam int CHARS     = 15;
    localparam int MAX_CYCLES = 400000;

    // one reported record as seen on the result ports
    typedef struct {
        logic [4:0]   id;
        logic [127:0] sur;
        logic [127:0] giv;
        logic [127:0] ph;
        logic [1:0]   st;
        logic         lst;
    } reply_t;

    // scoreboard: private copy of the table, predicts replies per accepted item
    class table_scoreboard;
        logic [127:0] sur_tbl [TBL_DEPTH];
        logic [127:0] giv_tbl [TBL_DEPTH];
        logic [127:0] ph_tbl  [TBL_DEPTH];
        int           count;
        reply_t       pending [$];
        int           errors;

        function void clear();
            count = 0;
            errors = 0;
            pending.delete();
        endfunction

        function logic [127:0] trim(logic [127:0] s);
            logic [127:0] r;
            logic         ended;
            r = '0;
            ended = 1'b0;
            for (int b = 0; b < 16; b++)
            begin
                if (b >= CHARS || s[127-8*b -: 8] == 8'd0)
                begin
                    ended = 1'b1;
                end
                if (!ended)
                begin
                    r[127-8*b -: 8] = s[127-8*b -: 8];
                end
            end
            return r;
        endfunction

        function void push(int idx, logic [1:0] st, logic lst);
            reply_t r;
            r.id = '0;
            r.sur = '0;
            r.giv = '0;
            r.ph = '0;
            if (idx >= 0)
            begin
                r.id = 5'(idx + 1);
                r.sur = sur_tbl[idx];
                r.giv = giv_tbl[idx];
                r.ph = ph_tbl[idx];
            end
            r.st = st;
            r.lst = lst;
            pending.push_back(r);
        endfunction

        function void sort_by(logic [2:0] fn);
            logic [127:0] ka;
            logic [127:0] kb;
            logic [127:0] t;
            for (int k = 0; k < count; k++)
            begin
                for (int x = k + 1; x < count; x++)
                begin
                    ka = (fn == FN_SORT_PHONE) ? ph_tbl[k] : sur_tbl[k];
                    kb = (fn == FN_SORT_PHONE) ? ph_tbl[x] : sur_tbl[x];
                    if (ka > kb)
                    begin
                        t = sur_tbl[k]; sur_tbl[k] = sur_tbl[x]; sur_tbl[x] = t;
                        t = giv_tbl[k]; giv_tbl[k] = giv_tbl[x]; giv_tbl[x] = t;
                        t = ph_tbl[k];  ph_tbl[k]  = ph_tbl[x];  ph_tbl[x]  = t;
                    end
                end
            end
        endfunction

        function void note_item(logic [2:0] fn, logic [127:0] s, logic [127:0] g,
                                logic [127:0] p, logic [4:0] pos);
            logic [127:0] key;
            logic [127:0] fld;
            int           hits;
            s = trim(s);
            g = trim(g);
            p = trim(p);
            case (fn)
                FN_LIST:
                begin
                    if (count == 0)
                    begin
                        push(-1, STAT_MISS, 1'b1);
                    end
                    for (int i = 0; i < count; i++)
                    begin
                        push(i, STAT_OK, i + 1 == count);
                    end
                end
                FN_INSERT:
                begin
                    if (count >= TBL_DEPTH)
                    begin
                        push(-1, STAT_FULL, 1'b1);
                    end
                    else
                    begin
                        sur_tbl[count] = s;
                        giv_tbl[count] = g;
                        ph_tbl[count] = p;
                        count++;
                        push(count - 1, STAT_OK, 1'b1);
                    end
                end
                FN_FIND_SUR, FN_FIND_GIVEN, FN_FIND_PHONE:
                begin
                    hits = 0;
                    key = (fn == FN_FIND_SUR) ? s : (fn == FN_FIND_GIVEN) ? g : p;
                    for (int i = 0; i < count; i++)
                    begin
                        fld = (fn == FN_FIND_SUR) ? sur_tbl[i] :
                              (fn == FN_FIND_GIVEN) ? giv_tbl[i] : ph_tbl[i];
                        if (fld == key)
                        begin
                            push(i, STAT_OK, 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0)
                    begin
                        push(-1, STAT_MISS, 1'b1);
                    end
                    else
                    begin
                        pending[pending.size() - 1].lst = 1'b1;
                    end
                end
                FN_SORT_PHONE, FN_SORT_SUR:
                begin
                    sort_by(fn);
                    push(-1, STAT_OK, 1'b1);
                end
                default:
                begin
                    if (pos == 0 || pos > count)
                    begin
                        push(-1, STAT_BADPOS, 1'b1);
                    end
                    else
                    begin
                        giv_tbl[pos - 1] = g;
                        push(pos - 1, STAT_OK, 1'b1);
                    end
                end
            endcase
        endfunction

        function void check_reply(reply_t got);
            reply_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result id %0d status %0d", $time, got.id, got.st);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.id !== exp.id)
            begin
                $display("%0t: record_id exp %0d got %0d", $time, exp.id, got.id);
                errors++;
            end
            if (got.sur !== exp.sur)
            begin
                $display("%0t: surname exp %h got %h", $time, exp.sur, got.sur);
                errors++;
            end
            if (got.giv !== exp.giv)
            begin
                $display("%0t: given exp %h got %h", $time, exp.giv, got.giv);
                errors++;
            end
            if (got.ph !== exp.ph)
            begin
                $display("%0t: phone exp %h got %h", $time, exp.ph, got.ph);
                errors++;
            end
            if (got.st !== exp.st)
            begin
                $display("%0t: status exp %0d got %0d", $time, exp.st, got.st);
                errors++;
            end
            if (got.lst !== exp.lst)
            begin
                $display("%0t: last exp %0d got %0d", $time, exp.lst, got.lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  func;
    logic [63:0] surname_hi;
    logic [63:0] surname_lo;
    logic [63:0] given_hi;
    logic [63:0] given_lo;
    logic [63:0] phone_hi;
    logic [63:0] phone_lo;
    logic [4:0]  position;
    logic        result_valid;
    logic [4:0]  record_id;
    logic [63:0] out_surname_hi;
    logic [63:0] out_surname_lo;
    logic [63:0] out_given_hi;
    logic [63:0] out_given_lo;
    logic [63:0] out_phone_hi;
    logic [63:0] out_phone_lo;
    logic [1:0]  status;
    logic        last;

    table_scoreboard board;
    int          cycle_count;
    // small pools so that searches hit and sorts see ties
    logic [127:0] name_pool [8];

    record_table_sort_search i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .surname_hi     (surname_hi),
        .surname_lo     (surname_lo),
        .given_hi       (given_hi),
        .given_lo       (given_lo),
        .phone_hi       (phone_hi),
        .phone_lo       (phone_lo),
        .position       (position),
        .result_valid   (result_valid),
        .record_id      (record_id),
        .out_surname_hi (out_surname_hi),
        .out_surname_lo (out_surname_lo),
        .out_given_hi   (out_given_hi),
        .out_given_lo   (out_given_lo),
        .out_phone_hi   (out_phone_hi),
        .out_phone_lo   (out_phone_lo),
        .status         (status),
        .last           (last)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // results cannot be held off, so every strobed cycle is checked at its closing edge
    always @(posedge clk)
    begin
        reply_t got;
        if (rst_n && result_valid)
        begin
            got.id = record_id;
            got.sur = {out_surname_hi, out_surname_lo};
            got.giv = {out_given_hi, out_given_lo};
            got.ph = {out_phone_hi, out_phone_lo};
            got.st = status;
            got.lst = last;
            board.check_reply(got);
        end
    end

    // watchdog: a run that goes on past MAX_CYCLES is reported as failed
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("record_table_sort_search verification failed");
            $finish;
        end
    end

    // random string: mostly from the pool, sometimes fully random bits (embedded zeros,
    // bytes past the character limit), sometimes short random text
    function automatic logic [127:0] pick_string();
        logic [127:0] s;
        int           sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            s = name_pool[$urandom_range(0, 7)];
        end
        else if (sel < 8)
        begin
            s = {$urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            s = '0;
            for (int b = 0; b < $urandom_range(1, 16); b++)
            begin
                s[127-8*b -: 8] = 8'($urandom_range(8'h41, 8'h5a));
            end
        end
        return s;
    endfunction

    // mostly short gaps, a few long, many with none; start stays high when there is no gap
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // present one item and hold it until the block takes it
    task automatic send_item(logic [2:0] fn, logic [127:0] s, logic [127:0] g,
                             logic [127:0] p, logic [4:0] pos);
        start <= 1'b1;
        func <= fn;
        {surname_hi, surname_lo} <= s;
        {given_hi, given_lo} <= g;
        {phone_hi, phone_lo} <= p;
        position <= pos;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        board.note_item(fn, s, g, p, pos);
        idle_gap();
    endtask

    task automatic send_random(logic [2:0] fn);
        send_item(fn, pick_string(), pick_string(), pick_string(),
                  5'($urandom_range(0, 18) < 18 ? $urandom_range(0, 17) : $urandom_range(0, 31)));
    endtask

    initial
    begin
        logic [2:0] fn;
        int         wait_cycles;
        board = new();
        board.clear();
        cycle_count = 0;
        for (int i = 0; i < 8; i++)
        begin
            name_pool[i] = {8'($urandom_range(8'h41, 8'h44)), 8'($urandom_range(8'h61, 8'h62)),
                            8'($urandom_range(0, 1) ? 8'h63 : 8'h00), 104'h0};
        end
        name_pool[7] = {128{1'b1}};
        start = 1'b0;
        func = FN_LIST;
        {surname_hi, surname_lo, given_hi, given_lo, phone_hi, phone_lo} = '0;
        position = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table cases
        send_item(FN_LIST, '0, '0, '0, 5'd0);
        send_item(FN_FIND_SUR, '0, '0, '0, 5'd0);
        send_item(FN_UPDATE, '0, '1, '0, 5'd1);
        send_item(FN_SORT_SUR, '0, '0, '0, 5'd0);
        // extremes: all ones (cut at char limit), all zeros, zero byte in the middle
        send_item(FN_INSERT, '1, '1, '1, 5'd31);
        send_item(FN_INSERT, '0, '0, '0, 5'd0);
        send_item(FN_INSERT, {8'h5a, 8'h00, 112'hffff_ffff}, {16{8'h41}},
                  {8'h30, 8'h31, 112'h0}, 5'd0);
        send_item(FN_INSERT, name_pool[0], name_pool[1], name_pool[2], 5'd0);
        send_item(FN_FIND_SUR, '1, '0, '0, 5'd0);
        send_item(FN_FIND_GIVEN, '0, {16{8'h41}}, '0, 5'd0);
        send_item(FN_FIND_PHONE, '0, '0, {8'h30, 8'h31, 8'h00, 104'h1}, 5'd0);
        send_item(FN_FIND_PHONE, '0, '0, 128'h99, 5'd0);
        send_item(FN_UPDATE, '0, name_pool[3], '0, 5'd4);
        send_item(FN_UPDATE, '0, name_pool[3], '0, 5'd5);
        send_item(FN_UPDATE, '0, name_pool[3], '0, 5'd0);
        send_item(FN_SORT_PHONE, '0, '0, '0, 5'd0);
        send_item(FN_LIST, '0, '0, '0, 5'd0);
        send_item(FN_SORT_SUR, '0, '0, '0, 5'd0);
        send_item(FN_LIST, '0, '0, '0, 5'd0);
        // fill to the top, then one more insert for the full status
        while (board.count < TBL_DEPTH)
        begin
            send_random(FN_INSERT);
        end
        send_random(FN_INSERT);
        send_item(FN_UPDATE, '0, '0, '0, 5'd16);
        send_item(FN_UPDATE, '0, '0, '0, 5'd17);

        // random: function codes drawn uniformly, so searches and sorts make up most items; the table stays full
        for (int n = 0; n < 136; n++)
        begin
            fn = 3'($urandom_range(0, 7));
            if (board.count < 4 && $urandom_range(0, 1))
            begin
                fn = FN_INSERT;
            end
            send_random(fn);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("record_table_sort_search verification clean");
        end
        else
        begin
            $display("record_table_sort_search verification failed");
        end
        $finish;
    end
endmodule
